// ===== rtl/cdd_pkg.sv =====
// Shared types, constants and the band classifier of the card detect decoder.
package cdd_pkg;

	localparam int SAMPLE_W        = 10;
	localparam int SUM_W           = 12;
	localparam int IDX_W           = 2;
	localparam int COUNT_W         = 4;
	localparam int CODE_W          = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 10;
	localparam int AVG_SAMPLES_DEF = 4;
	localparam int NUM_BANDS       = 8;

	localparam logic [SAMPLE_W-1:0] PRESENT_RESET = 10'd300;
	localparam logic [SAMPLE_W-1:0] ABSENT_RESET  = 10'd700;
	localparam logic [COUNT_W-1:0]  CONFIRM_RESET = 4'd5;

	localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABSENT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 2'd2;

	localparam logic EV_INSERT = 1'b0;
	localparam logic EV_REMOVE = 1'b1;

	localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;

	// Upper bounds of the resistor bands, lowest band first.
	localparam logic [SAMPLE_W-1:0] BAND_LIMIT [NUM_BANDS] = '{
		10'd138, 10'd256, 10'd420, 10'd608, 10'd765, 10'd877, 10'd953, 10'd995
	};

	typedef enum logic {
		PH_WAIT,
		PH_CARD
	} phase_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] light_sample;
		logic [SAMPLE_W-1:0] card_sample;
	} in_item_t;

	typedef struct packed {
		logic                event_kind;
		logic [CODE_W-1:0]   card_code;
		logic [SAMPLE_W-1:0] card_average;
		logic [SAMPLE_W-1:0] light_average;
	} out_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] light_avg;
		logic [SAMPLE_W-1:0] card_avg;
	} avg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] present_threshold;
		logic [SAMPLE_W-1:0] absent_threshold;
		logic [COUNT_W-1:0]  confirm_count;
	} cfg_t;

	// Lowest band whose limit lies above the average; code zero above all bands.
	function automatic logic [CODE_W-1:0] band_of(input logic [SAMPLE_W-1:0] avg);
		logic [CODE_W-1:0] code;
		code = CODE_NONE;
		for (int k = NUM_BANDS - 1; k >= 0; k--) begin
			if (avg < BAND_LIMIT[k]) begin
				code = CODE_W'(k + 1);
			end
		end
		return code;
	endfunction

endpackage

// ===== rtl/cdd_avg.sv =====
// Sample accumulator and window averager of the card detect decoder.
module cdd_avg
	import cdd_pkg::*;
#(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	input  logic     s1_ready,
	output logic     s1_valid,
	output avg_t     s1_avg
);

	// Division by the window length as a multiply by a rounded-up reciprocal.
	// The sum never exceeds four full-scale samples, so the result is exact.
	localparam int RECIP_SH = 13;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((2 ** RECIP_SH + AVG_SAMPLES - 1) / AVG_SAMPLES);
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_SAMPLES - 1);

	logic [SUM_W-1:0]  light_sum_q, card_sum_q;
	logic [SUM_W-1:0]  light_next, card_next;
	logic [IDX_W-1:0]  idx_q;
	logic [PROD_W-1:0] light_prod, card_prod;
	logic              s1_valid_s1;
	avg_t              avg_s1;
	logic              accept, last;

	assign in_stall = s1_valid_s1 && !s1_ready;
	assign accept   = in_valid && !in_stall;
	assign last     = (idx_q == LAST_IDX);

	assign light_next = light_sum_q + SUM_W'(in_item.light_sample);
	assign card_next  = card_sum_q + SUM_W'(in_item.card_sample);
	assign light_prod = PROD_W'(light_next) * PROD_W'(RECIP);
	assign card_prod  = PROD_W'(card_next) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_sum_q <= '0;
			card_sum_q  <= '0;
			idx_q       <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (last) begin
					light_sum_q <= '0;
					card_sum_q  <= '0;
					idx_q       <= '0;
					s1_valid_s1 <= 1'b1;
				end else begin
					light_sum_q <= light_next;
					card_sum_q  <= card_next;
					idx_q       <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			avg_s1.light_avg <= light_prod[RECIP_SH +: SAMPLE_W];
			avg_s1.card_avg  <= card_prod[RECIP_SH +: SAMPLE_W];
		end
	end

	assign s1_valid = s1_valid_s1;
	assign s1_avg   = avg_s1;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("sample index ran past the window");

	a_window_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (idx_q == '0 && light_sum_q == '0 && card_sum_q == '0
			&& s1_valid_s1))
		else $error("window close did not clear sums and post an average");

endmodule

// ===== rtl/cdd_debounce.sv =====
// Debounce phase machine, band classifier and event register of the card decoder.
module cdd_debounce
	import cdd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      s1_valid,
	input  avg_t      s1_avg,
	output logic      s1_ready,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	phase_t               phase_q, phase_d;
	logic [COUNT_W-1:0]   count_q, count_d;
	logic [COUNT_W:0]     count_inc;
	logic                 qualify, fire, take;
	logic                 out_valid_q;
	out_item_t            item_q, item_d;

	assign s1_ready = !out_valid_q || !out_stall;
	assign take     = s1_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			count_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		count_inc = {1'b0, count_q} + (COUNT_W + 1)'(1);
		phase_d   = phase_q;
		count_d   = count_q;
		item_d    = '0;
		unique case (phase_q)
			PH_WAIT: qualify = s1_avg.light_avg < cfg.present_threshold;
			PH_CARD: qualify = s1_avg.light_avg > cfg.absent_threshold;
			default: qualify = 1'b0;
		endcase
		fire = qualify && (count_inc >= {1'b0, cfg.confirm_count});
		item_d.card_average  = s1_avg.card_avg;
		item_d.light_average = s1_avg.light_avg;
		if (phase_q == PH_WAIT) begin
			item_d.event_kind = EV_INSERT;
			item_d.card_code  = band_of(s1_avg.card_avg);
		end else begin
			item_d.event_kind = EV_REMOVE;
			item_d.card_code  = CODE_NONE;
		end
		if (!qualify) begin
			count_d = '0;
		end else if (fire) begin
			count_d = '0;
			phase_d = (phase_q == PH_WAIT) ? PH_CARD : PH_WAIT;
		end else begin
			count_d = count_inc[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && fire) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && fire) begin
			item_q <= item_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = item_q;

	a_fire_flips: assert property (@(posedge clk) disable iff (!arst_n)
		(take && fire) |=> (count_q == '0 && phase_q != $past(phase_q)))
		else $error("confirmed average did not flip the phase");

	a_kind_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(take && fire) |=> (out_item.event_kind == ((phase_q == PH_WAIT) ?
			EV_REMOVE : EV_INSERT)))
		else $error("event kind disagrees with the new phase");

	a_removal_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.event_kind == EV_REMOVE) |-> out_item.card_code == CODE_NONE)
		else $error("removal event carries a band code");

endmodule

// ===== rtl/card_detect_debounce_band_decoder.sv =====
// Top level of the card detect decoder: configuration registers and the two stages.
// An item that closes an averaging window has its averages registered in stage one and,
// if it confirms a phase change, its event registered in stage two; the other items give
// no result. Throughput is one item per cycle while the input is not stalled.
// Reset (arst_n, asynchronous, active low) clears the sums, the window index, the
// debounce count and phase, both valid flags, and loads the configuration defaults.
module card_detect_debounce_band_decoder
	import cdd_pkg::*;
#(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item
);

	// Configuration registers. Writes to the unused index are dropped, and each
	// register keeps the low bits of the written value.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.present_threshold <= PRESENT_RESET;
			cfg_q.absent_threshold  <= ABSENT_RESET;
			cfg_q.confirm_count     <= CONFIRM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESENT: cfg_q.present_threshold <= cfg_data[SAMPLE_W-1:0];
				REG_ABSENT:  cfg_q.absent_threshold  <= cfg_data[SAMPLE_W-1:0];
				REG_CONFIRM: cfg_q.confirm_count     <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage one sums the samples and posts one average pair per window. Stage two
	// steps the debounce machine and holds the event until it is taken. Each stage
	// has its own valid flag, so a waiting event does not block the accumulator
	// while the average register is free.
	logic s1_valid, s1_ready;
	avg_t s1_avg;

	cdd_avg #(
		.AVG_SAMPLES(AVG_SAMPLES)
	) u_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.s1_ready (s1_ready),
		.s1_valid (s1_valid),
		.s1_avg   (s1_avg)
	);

	cdd_debounce u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s1_valid  (s1_valid),
		.s1_avg    (s1_avg),
		.s1_ready  (s1_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the card detect, debounce and band decoder block.
`timescale 1ns / 1ps

module testbench;
	import cdd_pkg::*;

	// The watchdog gives up after this many cycles in which neither side moves an item.
	localparam int STALL_LIMIT = 4000;
	// Length of the one long output hold-off that forces the block to stall its input.
	localparam int HOLD_CYCLES = 400;
	// Settling wait after the last predicted event has been taken.
	localparam int DRAIN_GAP   = 6;
	// Unused register index; writes there are expected to have no effect.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {
		LIGHT_DARK,
		LIGHT_BRIGHT,
		LIGHT_NOISE
	} light_mode_t;

	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} stall_style_t;

	// Keeps its own copy of the decoder state, predicts the card events and checks them
	// in order against what the block delivers.
	class card_event_board;
		logic [SAMPLE_W-1:0] present_level;
		logic [SAMPLE_W-1:0] absent_level;
		logic [COUNT_W-1:0]  confirm_level;
		phase_t              phase;
		logic [COUNT_W-1:0]  streak;
		int                  fill;
		logic [SUM_W-1:0]    light_acc;
		logic [SUM_W-1:0]    card_acc;
		out_item_t           pending[$];
		int                  errors;

		function new();
			present_level = PRESENT_RESET;
			absent_level  = ABSENT_RESET;
			confirm_level = CONFIRM_RESET;
			phase         = PH_WAIT;
			streak        = '0;
			fill          = 0;
			light_acc     = '0;
			card_acc      = '0;
			errors        = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PRESENT: present_level = data[SAMPLE_W-1:0];
				REG_ABSENT:  absent_level  = data[SAMPLE_W-1:0];
				REG_CONFIRM: confirm_level = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CODE_W-1:0] resistor_band(logic [SAMPLE_W-1:0] avg);
			for (int k = 0; k < NUM_BANDS; k++) begin
				if (avg < BAND_LIMIT[k]) begin
					return CODE_W'(k + 1);
				end
			end
			return CODE_NONE;
		endfunction

		function void note_sample(in_item_t s);
			logic [SAMPLE_W-1:0] light_avg;
			logic [SAMPLE_W-1:0] card_avg;
			logic                qualifies;
			out_item_t           ev;
			light_acc = light_acc + SUM_W'(s.light_sample);
			card_acc  = card_acc + SUM_W'(s.card_sample);
			fill++;
			if (fill < AVG_SAMPLES_DEF) begin
				return;
			end
			light_avg = SAMPLE_W'(light_acc / AVG_SAMPLES_DEF);
			card_avg  = SAMPLE_W'(card_acc / AVG_SAMPLES_DEF);
			light_acc = '0;
			card_acc  = '0;
			fill      = 0;
			qualifies = (phase == PH_WAIT) ? (light_avg < present_level)
			                               : (light_avg > absent_level);
			if (!qualifies) begin
				streak = '0;
				return;
			end
			// A confirm count of zero acts as one, since the compare follows the increment.
			if (int'(streak) + 1 < int'(confirm_level)) begin
				streak = streak + COUNT_W'(1);
				return;
			end
			streak           = '0;
			ev.card_average  = card_avg;
			ev.light_average = light_avg;
			if (phase == PH_WAIT) begin
				ev.event_kind = EV_INSERT;
				ev.card_code  = resistor_band(card_avg);
				phase         = PH_CARD;
			end else begin
				ev.event_kind = EV_REMOVE;
				ev.card_code  = CODE_NONE;
				phase         = PH_WAIT;
			end
			pending.push_back(ev);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_event(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t ns: event with none expected, expected nothing actual %h",
				         $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
			compare_field("card_code", 32'(want.card_code), 32'(got.card_code));
			compare_field("card_average", 32'(want.card_average), 32'(got.card_average));
			compare_field("light_average", 32'(want.light_average),
			              32'(got.light_average));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_PRESENT;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	in_item_t              in_item    = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	out_item_t             out_item;

	card_event_board board = new();

	// Sender burst bookkeeping; a huge value keeps the sender offering items back to back.
	int burst_left = 0;
	// Set once by the stimulus to ask the receiver for its long hold-off.
	bit hold_req   = 1'b0;

	// Receiver state, owned by the receiver process below.
	bit           hold_done    = 1'b0;
	int           hold_left    = 0;
	int           stretch_left = 0;
	stall_style_t stall_style  = RX_FREE;
	int           idle_cycles  = 0;

	card_detect_debounce_band_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: checks every event that is taken, picks a stall style for stretches of
	// random length, serves the one long hold-off on request, and runs the watchdog.
	// Signals are read right after the edge, so they hold their values from before it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				board.check_event(out_item);
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t ns: watchdog expired, no item moved for %0d cycles",
				         $time, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (stretch_left == 0) begin
					stall_style  = stall_style_t'($urandom_range(0, 3));
					stretch_left = $urandom_range(8, 96);
				end
				stretch_left--;
				case (stall_style)
					RX_FREE:   out_stall <= 1'b0;
					RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
					default:   out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Writes all registers, the unused index included, on consecutive edges. The block
	// must be idle when this is called. Write enable stays high across the writes so it
	// is only lowered once, after the last one.
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] present,
	                              input logic [CFG_DATA_W-1:0] absent,
	                              input logic [CFG_DATA_W-1:0] confirm);
		logic [CFG_IDX_W-1:0]  order [4];
		logic [CFG_DATA_W-1:0] vals  [4];
		order = '{REG_PRESENT, REG_ABSENT, REG_CONFIRM, REG_SPARE};
		vals  = '{present, absent, confirm, CFG_DATA_W'($urandom)};
		for (int k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= order[k];
			cfg_data  <= vals[k];
			@(posedge clk);
			board.set_register(order[k], vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// Offers one item and waits until it is taken. Items go out in bursts; between bursts
	// valid drops for a random gap, and sometimes there is no gap at all.
	task automatic push_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		board.note_sample(it);
	endtask

	// One averaging window of identical samples, so the averages are exact.
	task automatic send_flat_window(input int light, input int card);
		in_item_t it;
		it.light_sample = SAMPLE_W'(light);
		it.card_sample  = SAMPLE_W'(card);
		for (int i = 0; i < AVG_SAMPLES_DEF; i++) begin
			push_item(it);
		end
	endtask

	// Random windows in runs. Most runs hold the light level on the side that moves the
	// debounce toward the next phase change, for a random number of windows that may
	// confirm it; the rest hold it on the wrong side, breaking the streak, or make noise.
	// Card readings: band edges, range ends, flat, jittered about a level, fully random.
	task automatic run_random(input int n_items);
		int          sent;
		int          run_windows;
		int          pick;
		int          lo;
		int          hi;
		int          card_base;
		int          card_style;
		int          card;
		bit          at_edge;
		light_mode_t mode;
		in_item_t    it;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				mode = (board.phase == PH_WAIT) ? LIGHT_DARK : LIGHT_BRIGHT;
			end else if (pick < 17) begin
				mode = (board.phase == PH_WAIT) ? LIGHT_BRIGHT : LIGHT_DARK;
			end else begin
				mode = LIGHT_NOISE;
			end
			if (mode == LIGHT_DARK && board.present_level == 0) begin
				mode = LIGHT_NOISE;
			end
			if (mode == LIGHT_BRIGHT && board.absent_level == 10'd1023) begin
				mode = LIGHT_NOISE;
			end
			case (mode)
				LIGHT_DARK: begin
					lo = 0;
					hi = int'(board.present_level) - 1;
				end
				LIGHT_BRIGHT: begin
					lo = int'(board.absent_level) + 1;
					hi = 1023;
				end
				default: begin
					lo = 0;
					hi = 1023;
				end
			endcase
			// Sitting one step past a threshold checks the strict compares.
			at_edge     = ($urandom_range(0, 4) == 0);
			run_windows = $urandom_range(1, int'(board.confirm_level) + 2);
			card_style  = $urandom_range(0, 4);
			case (card_style)
				0:       card_base = int'(BAND_LIMIT[$urandom_range(0, NUM_BANDS - 1)])
				                     - $urandom_range(0, 1);
				1:       card_base = ($urandom_range(0, 1) == 0) ? 0 : 1023;
				default: card_base = $urandom_range(0, 1023);
			endcase
			for (int w = 0; w < run_windows; w++) begin
				for (int i = 0; i < AVG_SAMPLES_DEF; i++) begin
					if (at_edge) begin
						it.light_sample = SAMPLE_W'((mode == LIGHT_BRIGHT) ? lo : hi);
					end else begin
						it.light_sample = SAMPLE_W'($urandom_range(hi, lo));
					end
					case (card_style)
						3: begin
							card = card_base + $urandom_range(0, 16) - 8;
							card = (card < 0) ? 0 : ((card > 1023) ? 1023 : card);
						end
						4:       card = $urandom_range(0, 1023);
						default: card = card_base;
					endcase
					it.card_sample = SAMPLE_W'(card);
					push_item(it);
					sent++;
				end
			end
		end
	endtask

	// Waits until every predicted event has come out, then lets the pipeline settle so
	// that the block is idle for a register write or the end of the run.
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (board.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	initial begin
		in_item_t it;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: thresholds that meet in the middle and a confirm count of one,
		// so each window that qualifies flips the phase at once.
		apply_settings(10'd512, 10'd511, 10'd1);
		// Mixed samples: averages truncate, light 3/4 gives 0 and card 1025/4 gives 256,
		// the first value of band three.
		it.light_sample = 10'd0;    it.card_sample = 10'd1023; push_item(it);
		it.light_sample = 10'd1;    it.card_sample = 10'd0;    push_item(it);
		it.light_sample = 10'd2;    it.card_sample = 10'd1;    push_item(it);
		it.light_sample = 10'd0;    it.card_sample = 10'd1;    push_item(it);
		// Full-scale light removes the card.
		send_flat_window(1023, 1023);
		// Light one below the present threshold inserts; card just under the first limit.
		send_flat_window(511, 137);
		// Light one above the absent threshold removes; card on the first limit.
		send_flat_window(512, 138);
		// Waiting with light on the present threshold itself does not qualify.
		send_flat_window(512, 500);
		// A card on the top limit is unrecognized and gets code zero.
		send_flat_window(0, 995);
		wait_drained();

		// Reset defaults written back explicitly.
		apply_settings(PRESENT_RESET, ABSENT_RESET, CFG_DATA_W'(CONFIRM_RESET));
		run_random(700);
		wait_drained();

		// Thresholds at the ends of the range can never be passed: no events at all.
		apply_settings(10'd0, 10'd1023, 10'd15);
		run_random(60);
		wait_drained();

		// Nearly every window qualifies and the confirm count wraps to zero, so each such
		// window gives an event. The receiver holds off for a long stretch while the sender
		// keeps offering items back to back, which fills the block and stalls its input.
		apply_settings(10'd1023, 10'd0, 10'h3F0);
		hold_req   = 1'b1;
		burst_left = 1000000;
		run_random(200);
		burst_left = 0;
		run_random(200);
		wait_drained();

		// A few random settings.
		for (int p = 0; p < 3; p++) begin
			apply_settings(CFG_DATA_W'($urandom_range(0, 1023)),
			               CFG_DATA_W'($urandom_range(0, 1023)),
			               CFG_DATA_W'($urandom_range(1, 15)));
			run_random(230);
			wait_drained();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cdd_pkg.sv
rtl/cdd_avg.sv
rtl/cdd_debounce.sv
rtl/card_detect_debounce_band_decoder.sv
bench/testbench.sv
